// ----- rtl/tswc_pkg.sv -----
// Shared types, codes and a helper function for the train stop warning controller.
package tswc_pkg;

    localparam logic [3:0] KIND_TICK    = 4'd0;
    localparam logic [3:0] KIND_INIT    = 4'd1;
    localparam logic [3:0] KIND_BTN_DN  = 4'd2;
    localparam logic [3:0] KIND_BTN_UP  = 4'd3;
    localparam logic [3:0] KIND_CANCEL  = 4'd4;
    localparam logic [3:0] KIND_LONG    = 4'd5;
    localparam logic [3:0] KIND_SHORT   = 4'd6;
    localparam logic [3:0] KIND_RESTORE = 4'd7;
    localparam logic [3:0] KIND_OFF     = 4'd8;
    localparam logic [3:0] KIND_PANEL   = 4'd9;
    localparam logic [3:0] KIND_NOTCH   = 4'd10;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CHIME = 2'd1;
    localparam logic [1:0] PH_ALARM = 2'd2;

    localparam logic [1:0] REG_CONFIRM_NOTCH   = 2'd0;
    localparam logic [1:0] REG_EMERGENCY_NOTCH = 2'd1;
    localparam logic [1:0] REG_BRAKE_DELAY     = 2'd2;
    localparam logic [1:0] REG_PASS_WINDOW     = 2'd3;

    localparam logic [3:0]  RST_CONFIRM_NOTCH   = 4'd1;
    localparam logic [3:0]  RST_EMERGENCY_NOTCH = 4'd9;
    localparam logic [15:0] RST_BRAKE_DELAY     = 16'd5000;
    localparam logic [15:0] RST_PASS_WINDOW     = 16'd375;

    localparam int unsigned BLINK_PERIOD = 750;
    localparam int unsigned BLINK_HALF   = 375;

    typedef struct packed {
        logic [3:0]  confirm_notch;
        logic [3:0]  emergency_notch;
        logic [15:0] brake_delay_ms;
        logic [15:0] pass_window_ms;
    } cfg_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] notch;
        logic       aspect_stop;
        logic       blink;
    } evt_t;

    function automatic logic [9:0] mod750_step8(input logic [9:0] r, input logic [7:0] b);
        logic [10:0] acc;
        logic [9:0]  res;
        int          i;
        res = r;
        for (i = 7; i >= 0; i--)
        begin
            acc = {res, b[i]};
            if (acc >= 11'(BLINK_PERIOD))
            begin
                acc = acc - 11'(BLINK_PERIOD);
            end
            res = acc[9:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/tswc_front.sv -----
// Front end: accepts events, classifies them and derives the blink phase of the time stamp.
module tswc_front
    import tswc_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           kind,
    input  logic [31:0]          time_ms,
    input  logic [3:0]           brake_notch,
    input  logic [7:0]           signal_aspect,
    input  logic                 q_full,
    output logic                 q_push,
    output evt_t                 q_evt,
    output logic [TIME_BITS-1:0] q_time
);

    localparam int NSTG = (TIME_BITS + 7) / 8;
    localparam int TPAD = NSTG * 8;

    logic                 valid_reg [NSTG];
    logic [9:0]           rem_reg   [NSTG];
    logic [TIME_BITS-1:0] time_reg  [NSTG];
    evt_t                 evt_reg   [NSTG];
    logic [9:0]           rem_next  [NSTG];

    logic [63:0]          time_wide;
    logic [TIME_BITS-1:0] time_in;
    logic [TPAD-1:0]      pad_in;
    logic [TPAD-1:0]      pad_stg   [NSTG];
    logic                 adv;
    evt_t                 evt_in;

    assign time_wide = {32'd0, time_ms};
    assign time_in   = time_wide[TIME_BITS-1:0];
    assign pad_in    = TPAD'(time_in);

    assign evt_in.kind        = kind;
    assign evt_in.notch       = brake_notch;
    assign evt_in.aspect_stop = (signal_aspect == 8'd0);
    assign evt_in.blink       = 1'b0;

    assign adv      = !valid_reg[NSTG-1] || !q_full;
    assign in_ready = adv;

    always_comb
    begin
        for (int s = 0; s < NSTG; s++)
        begin
            pad_stg[s] = TPAD'(time_reg[s]);
        end
        rem_next[0] = mod750_step8(10'd0, pad_in[TPAD-1 -: 8]);
        for (int s = 1; s < NSTG; s++)
        begin
            rem_next[s] = mod750_step8(rem_reg[s-1], pad_stg[s-1][TPAD-1-8*s -: 8]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < NSTG; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= rem_next[0];
            time_reg[0] <= time_in;
            evt_reg[0]  <= evt_in;
            for (int s = 1; s < NSTG; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                time_reg[s] <= time_reg[s-1];
                evt_reg[s]  <= evt_reg[s-1];
            end
        end
    end

    assign q_push = valid_reg[NSTG-1] && !q_full;
    assign q_time = time_reg[NSTG-1];

    always_comb
    begin
        q_evt       = evt_reg[NSTG-1];
        q_evt.blink = (rem_reg[NSTG-1] >= 10'(BLINK_HALF));
    end

endmodule

// ----- rtl/tswc_fifo.sv -----
// Short register queue between the front end and the back end.
module tswc_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/tswc_back.sv -----
// Back end: alarm, brake and lamp state update with the registered result.
module tswc_back
    import tswc_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  evt_t                 q_evt,
    input  logic [TIME_BITS-1:0] q_time,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [4:0]           out_bits
);

    logic [1:0]           phase_reg, phase_next;
    logic                 brake_reg, brake_next;
    logic                 held_reg, held_next;
    logic [TIME_BITS-1:0] bdl_reg, bdl_next;
    logic [TIME_BITS-1:0] cdl_reg, cdl_next;
    logic                 bell_reg, bell_next;
    logic                 chime_reg, chime_next;
    logic                 white_reg, white_next;
    logic                 red_reg, red_next;
    logic                 out_valid_reg;
    logic [4:0]           out_bits_reg;

    logic [TIME_BITS-1:0] brake_at, confirm_at;
    logic                 btn_ok;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                     input logic [15:0] d);
        logic [TIME_BITS:0] s;
        s = {1'b0, t} + (TIME_BITS+1)'(d);
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    assign brake_at   = sat_add(q_time, cfg.brake_delay_ms);
    assign confirm_at = sat_add(q_time, cfg.pass_window_ms);
    assign q_pop      = !q_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        phase_next = phase_reg;
        brake_next = brake_reg;
        held_next  = held_reg;
        bdl_next   = bdl_reg;
        cdl_next   = cdl_reg;
        bell_next  = bell_reg;
        chime_next = chime_reg;
        white_next = white_reg;
        red_next   = red_reg;
        btn_ok     = (q_evt.notch >= cfg.confirm_notch);
        case (q_evt.kind)
            KIND_TICK:
            begin
                if (phase_reg == PH_ALARM)
                begin
                    if (cdl_reg != '0 && q_time >= cdl_reg && !brake_reg)
                    begin
                        phase_next = PH_CHIME;
                        bell_next  = 1'b0;
                        chime_next = 1'b1;
                        white_next = 1'b1;
                        red_next   = 1'b0;
                    end
                    if (q_time >= bdl_reg)
                    begin
                        brake_next = 1'b1;
                    end
                    if (brake_next)
                    begin
                        red_next = q_evt.blink;
                    end
                end
            end
            KIND_INIT, KIND_OFF:
            begin
                brake_next = 1'b0;
                phase_next = PH_IDLE;
                bell_next  = 1'b0;
                chime_next = 1'b0;
                white_next = (q_evt.kind == KIND_INIT);
                red_next   = 1'b0;
            end
            KIND_BTN_DN, KIND_NOTCH:
            begin
                if (q_evt.kind == KIND_BTN_DN)
                begin
                    held_next = 1'b1;
                end
                if (btn_ok && held_next && phase_reg == PH_ALARM && !brake_reg)
                begin
                    phase_next = PH_CHIME;
                    bell_next  = 1'b0;
                    chime_next = 1'b1;
                    white_next = 1'b1;
                    red_next   = 1'b0;
                end
            end
            KIND_BTN_UP:
            begin
                held_next = 1'b0;
            end
            KIND_CANCEL:
            begin
                if (phase_reg == PH_CHIME)
                begin
                    phase_next = PH_IDLE;
                    chime_next = 1'b0;
                end
            end
            KIND_LONG, KIND_SHORT:
            begin
                if (!q_evt.aspect_stop)
                begin
                    if (!white_reg)
                    begin
                        bdl_next   = brake_at;
                        cdl_next   = confirm_at;
                        phase_next = PH_ALARM;
                        chime_next = 1'b0;
                        bell_next  = 1'b1;
                        white_next = 1'b0;
                        red_next   = 1'b1;
                    end
                end
                else if (q_evt.kind == KIND_LONG)
                begin
                    if (phase_reg != PH_ALARM)
                    begin
                        bdl_next   = brake_at;
                        cdl_next   = '0;
                        phase_next = PH_ALARM;
                        chime_next = 1'b0;
                        bell_next  = 1'b1;
                        white_next = 1'b0;
                        red_next   = 1'b1;
                    end
                end
                else if (!brake_reg)
                begin
                    brake_next = 1'b1;
                    if (phase_reg != PH_ALARM)
                    begin
                        phase_next = PH_ALARM;
                        chime_next = 1'b0;
                        bell_next  = 1'b1;
                        white_next = 1'b0;
                        red_next   = 1'b1;
                    end
                end
            end
            KIND_RESTORE:
            begin
                if (q_evt.notch == cfg.emergency_notch && brake_reg)
                begin
                    brake_next = 1'b0;
                    phase_next = PH_IDLE;
                    bell_next  = 1'b0;
                    white_next = 1'b1;
                    red_next   = 1'b0;
                end
            end
            KIND_PANEL:
            begin
                bell_next = 1'b1;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            brake_reg     <= 1'b0;
            held_reg      <= 1'b0;
            bdl_reg       <= '0;
            cdl_reg       <= '0;
            bell_reg      <= 1'b0;
            chime_reg     <= 1'b0;
            white_reg     <= 1'b0;
            red_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            phase_reg     <= phase_next;
            brake_reg     <= brake_next;
            held_reg      <= held_next;
            bdl_reg       <= bdl_next;
            cdl_reg       <= cdl_next;
            bell_reg      <= bell_next;
            chime_reg     <= chime_next;
            white_reg     <= white_next;
            red_reg       <= red_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_bits_reg <= {red_next, white_next, chime_next, bell_next, brake_next};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bits  = out_bits_reg;

endmodule

// ----- rtl/train_stop_warning_controller_unit.sv -----
// Top level of the train stop warning controller: register port, front end, queue, back end.
//
//  channel  | dir | handshake                      | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | event: kind, time, notch, aspect
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | brake, bell, chime, white, red
//  apb      | in  | psel / penable / pready        | four configuration registers
//
// One event per cycle sustained while m_axis_tready keeps the output draining; each
// event passes the byte-per-stage modulo-750 pipeline that derives the red lamp blink phase.
// Reset clears the alarm state, the deadlines and the queue; registers take 1, 9, 5000, 375.
// A stalled output fills the four-entry queue, then the front end holds s_axis_tready low.
module train_stop_warning_controller_unit
    import tswc_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // kind[3:0], time_ms[35:4], brake_notch[39:36],
                                        // signal_aspect[47:40]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // brake_on[0], bell_on[1], chime_on[2],
                                        // white_lamp[3], red_lamp[4], zero[7:5]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QDEPTH = 4;
    localparam int QW     = $bits(evt_t) + TIME_BITS;

    cfg_t                 cfg_reg;
    logic                 q_push, q_pop, q_full, q_empty;
    evt_t                 f_evt, b_evt;
    logic [TIME_BITS-1:0] f_time, b_time;
    logic [QW-1:0]        q_rdata;
    logic [4:0]           out_bits;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confirm_notch   <= RST_CONFIRM_NOTCH;
            cfg_reg.emergency_notch <= RST_EMERGENCY_NOTCH;
            cfg_reg.brake_delay_ms  <= RST_BRAKE_DELAY;
            cfg_reg.pass_window_ms  <= RST_PASS_WINDOW;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_CONFIRM_NOTCH:   cfg_reg.confirm_notch   <= pwdata[3:0];
                REG_EMERGENCY_NOTCH: cfg_reg.emergency_notch <= pwdata[3:0];
                REG_BRAKE_DELAY:     cfg_reg.brake_delay_ms  <= pwdata[15:0];
                REG_PASS_WINDOW:     cfg_reg.pass_window_ms  <= pwdata[15:0];
                default:             cfg_reg.pass_window_ms  <= cfg_reg.pass_window_ms;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CONFIRM_NOTCH:   prdata = {28'd0, cfg_reg.confirm_notch};
            REG_EMERGENCY_NOTCH: prdata = {28'd0, cfg_reg.emergency_notch};
            REG_BRAKE_DELAY:     prdata = {16'd0, cfg_reg.brake_delay_ms};
            REG_PASS_WINDOW:     prdata = {16'd0, cfg_reg.pass_window_ms};
            default:             prdata = 32'd0;
        endcase
    end

    tswc_front #(.TIME_BITS(TIME_BITS)) u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .kind          (s_axis_tdata[3:0]),
        .time_ms       (s_axis_tdata[35:4]),
        .brake_notch   (s_axis_tdata[39:36]),
        .signal_aspect (s_axis_tdata[47:40]),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_evt         (f_evt),
        .q_time        (f_time)
    );

    tswc_fifo #(.WIDTH(QW), .DEPTH(QDEPTH)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({f_evt, f_time}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign b_evt  = q_rdata[QW-1 -: $bits(evt_t)];
    assign b_time = q_rdata[TIME_BITS-1:0];

    tswc_back #(.TIME_BITS(TIME_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_evt     (b_evt),
        .q_time    (b_time),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_bits  (out_bits)
    );

    assign m_axis_tdata = {3'd0, out_bits};

endmodule

// ----- rtl/tswc_checker.sv -----
// Port-level checker for the train stop warning controller and its bind.
module tswc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result dropped without transfer");

    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready && m_axis_tready |=> s_axis_tready)
        else $error("input stall outlived output drain");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=>
        (paddr[3:2] != $past(paddr[3:2])) ||
        (prdata == ($past(pwdata) & (paddr[3] ? 32'h0000_FFFF : 32'h0000_000F))))
        else $error("register readback mismatch");

endmodule

bind train_stop_warning_controller_unit tswc_checker u_tswc_checker (.*);
